// File: rtl/core/kdct_pkg.sv
package kdct_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 1024;

  localparam int unsigned KEY_W   = 22;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned TOTAL_W = 11;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // key * 3 fits in 24 bits; the same width sets the reciprocal scaling.
  localparam int unsigned HASH_W = KEY_W + 2;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 3;

  typedef struct packed {
    logic [TOTAL_W-1:0] count;
    logic               became;
    logic               full;
    logic               is_new;
    logic [CNT_W-1:0]   sdelta;
    logic [CNT_W-1:0]   udelta;
    logic [SLOT_W-1:0]  slot;
  } result_t;

endpackage

// File: rtl/core/kdct_hash.sv
module kdct_hash #(
  parameter int unsigned TABLE_SIZE = kdct_pkg::TABLE_SIZE_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_SIZE)
) (
  input  logic                     clk,
  input  logic [kdct_pkg::KEY_W-1:0] key,
  output logic [IDX_W-1:0]         home
);
  import kdct_pkg::*;

  localparam int unsigned TS_W = $clog2(TABLE_SIZE + 1);
  localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_SIZE);
  localparam logic [TS_W-1:0]   TSIZE = TS_W'(TABLE_SIZE);
  localparam logic [HASH_W-1:0] TSIZE_H = HASH_W'(TABLE_SIZE);

  logic [HASH_W-1:0]      x_c;
  logic [2*HASH_W-1:0]    prod_c;
  logic [HASH_W-1:0]      prod;
  logic [HASH_W-1:0]      x1;
  logic [HASH_W+TS_W-1:0] qt_c;
  logic [HASH_W-1:0]      qt;
  logic [HASH_W-1:0]      x2;
  logic [HASH_W-1:0]      rem;
  logic [HASH_W-1:0]      rem_fix;

  assign x_c    = {2'b00, key} + {1'b0, key, 1'b0};
  assign prod_c = x_c * RECIP;

  // The quotient estimate from the truncated reciprocal is exact or one low,
  // so a single compare and subtract finishes the remainder.
  assign qt_c    = prod * TSIZE;
  assign rem     = x2 - qt;
  assign rem_fix = (rem >= TSIZE_H) ? rem - TSIZE_H : rem;
  assign home    = IDX_W'(rem_fix);

  always_ff @(posedge clk) begin
    prod <= prod_c[2*HASH_W-1:HASH_W];
    x1   <= x_c;
    qt   <= qt_c[HASH_W-1:0];
    x2   <= x1;
  end

endmodule

// File: rtl/core/keyed_delta_counter_table.sv
// Hash table of TABLE_SIZE slots keyed by a 22-bit process id. Each input
// item carries a key and two cumulative counters; the block finds the key by
// linear probing from slot (key * 3) mod TABLE_SIZE, claims the first empty
// slot for a new key, stores the counters and returns their differences from
// the stored values, together with the slot, activity flags and the running
// count of active entries; if all TABLE_SIZE slots are probed without a match
// or an empty slot, it returns only the table-full flag and the count. After
// the item is accepted, ST_HASH1 and ST_HASH2 compute the home slot, ST_HASH3
// reads it, and the table memory's single read port then examines one slot
// per cycle: one if the key sits in its home slot, at most TABLE_SIZE. After
// reset the block clears every slot before it takes its first item. A finished
// result waits in an output register and does not block the next item's
// hashing; one that finds that register full waits in ST_HOLD and blocks new items.
module keyed_delta_counter_table #(
  parameter int unsigned TABLE_SIZE = kdct_pkg::TABLE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // key_id[21:0], user_ticks[53:22], system_ticks[85:54], zero pad
  input  logic [kdct_pkg::IN_DATA_W-1:0]  s_tdata,
  // baseline[0]
  input  logic [kdct_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot[9:0], user_delta[41:10], system_delta[73:42], active_count[84:74], zero pad
  output logic [kdct_pkg::OUT_DATA_W-1:0] m_tdata,
  // is_new[0], table_full[1], became_active[2]
  output logic [kdct_pkg::OUT_USER_W-1:0] m_tuser
);
  import kdct_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

  typedef struct packed {
    logic             valid;
    logic             active;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] user;
    logic [CNT_W-1:0] sys;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_HASH3,
    ST_PROBE,
    ST_HOLD
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_idx;
  logic [KEY_W-1:0]   key_r;
  logic [CNT_W-1:0]   user_r;
  logic [CNT_W-1:0]   sys_r;
  logic               base_r;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   probe_n;
  logic [TOTAL_W-1:0] active_total;
  result_t            pending;
  result_t            out_res;

  entry_t             mem [TABLE_SIZE];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic [IDX_W-1:0]   home;
  logic [IDX_W-1:0]   next_idx;
  logic               hit;
  logic               empty;
  logic               found;
  logic               done;
  logic [CNT_W-1:0]   du;
  logic [CNT_W-1:0]   ds;
  logic               act;
  logic [TOTAL_W-1:0] total_next;
  result_t            res_c;
  logic               out_free;
  logic               out_load;

  kdct_hash #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_hash (
    .clk  (clk),
    .key  (key_r),
    .home (home)
  );

  assign next_idx = (cur_idx == IDX_LAST) ? '0 : cur_idx + 1'b1;

  assign hit   = rd_data.valid && (rd_data.key == key_r);
  assign empty = !rd_data.valid;
  assign found = hit || empty;
  assign done  = found || (probe_n == IDX_LAST);

  // Cleared slots hold zero counters, so a new key gets its raw counters back.
  assign du  = user_r - rd_data.user;
  assign ds  = sys_r - rd_data.sys;
  assign act = found && !base_r && ((du != '0) || (ds != '0)) && !rd_data.active;

  assign total_next = (act && (active_total != TOTAL_MAX)) ? active_total + 1'b1
                                                           : active_total;

  always_comb begin
    res_c = '0;
    if (found) begin
      res_c.slot   = SLOT_W'(cur_idx);
      res_c.udelta = du;
      res_c.sdelta = ds;
      res_c.is_new = empty;
      res_c.became = act;
    end else begin
      res_c.full = 1'b1;
    end
    res_c.count = total_next;
  end

  always_comb begin
    unique case (state)
      ST_HASH3: rd_addr = home;
      ST_PROBE: rd_addr = next_idx;
      default:  rd_addr = cur_idx;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if ((state == ST_PROBE) && found) begin
      wr_en          = 1'b1;
      wr_data.valid  = 1'b1;
      wr_data.active = rd_data.active || act;
      wr_data.key    = key_r;
      wr_data.user   = user_r;
      wr_data.sys    = sys_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (((state == ST_PROBE) && done) || (state == ST_HOLD));
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      active_total <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            key_r  <= s_tdata[KEY_W-1:0];
            user_r <= s_tdata[KEY_W +: CNT_W];
            sys_r  <= s_tdata[KEY_W+CNT_W +: CNT_W];
            base_r <= s_tuser[0];
            state  <= ST_HASH1;
          end
        end
        ST_HASH1: state <= ST_HASH2;
        ST_HASH2: state <= ST_HASH3;
        ST_HASH3: begin
          cur_idx <= home;
          probe_n <= '0;
          state   <= ST_PROBE;
        end
        ST_PROBE: begin
          if (done) begin
            active_total <= total_next;
            if (out_free) begin
              out_res <= res_c;
              state   <= ST_IDLE;
            end else begin
              pending <= res_c;
              state   <= ST_HOLD;
            end
          end else begin
            cur_idx <= next_idx;
            probe_n <= probe_n + 1'b1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_res <= pending;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {(OUT_DATA_W - SLOT_W - 2*CNT_W - TOTAL_W)'(0), out_res.count,
                    out_res.sdelta, out_res.udelta, out_res.slot};
  assign m_tuser = {out_res.became, out_res.full, out_res.is_new};

endmodule
